// ----- design/psola_pitch_shift_frame_unit_macros.svh -----
// assertion helpers used by psola_back.sv
`ifndef PSOLA_PITCH_SHIFT_FRAME_UNIT_MACROS_SVH
`define PSOLA_PITCH_SHIFT_FRAME_UNIT_MACROS_SVH

// condition implies property in the same cycle
`define PSOLA_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("psola assertion failed");

// condition implies property in the next cycle
`define PSOLA_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("psola assertion failed");

`endif

// ----- design/psola_pkg.sv -----
`default_nettype none
package psola_pkg;

  localparam int MaxFrame = 512;
  localparam int IdxW = 10;
  localparam int SampleW = 16;
  localparam int ForceWeight = 32767;
  localparam int RoundBias = 16384;
  localparam int QBits = 15;

  localparam logic [2:0] RegFrameLength = 3'd0;
  localparam logic [2:0] RegAnalysisPeriod = 3'd1;
  localparam logic [2:0] RegSynthesisPeriod = 3'd2;
  localparam logic [2:0] RegWindowSlope = 3'd3;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [IdxW-1:0] idx;
    logic last;
  } psola_item_t;

  typedef struct packed {
    logic [9:0] len;
    logic [8:0] ap;
    logic [9:0] sp;
    logic [16:0] slope;
  } psola_cfg_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_RESP, ST_CHK, ST_RD, ST_WT, ST_MUL, ST_WR, ST_CRD, ST_CWR
  } psola_state_t;

endpackage
`default_nettype wire

// ----- design/psola_front.sv -----
`default_nettype none
module psola_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic signed [15:0] in_sample,
  input  wire logic [9:0] len,
  input  wire logic q_full,
  input  wire logic hold,
  output logic in_stall,
  output logic push,
  output psola_pkg::psola_item_t item
);

  logic [9:0] count;
  logic last;

  assign last = ((11'(count) + 11'd1) >= 11'(len));
  assign in_stall = q_full | hold;
  assign push = in_valid & ~in_stall;

  always_comb begin
    item.sample = in_sample;
    item.idx = count;
    item.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= last ? '0 : count + 10'd1;
    end
  end

endmodule
`default_nettype wire

// ----- design/psola_queue.sv -----
`default_nettype none
module psola_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire psola_pkg::psola_item_t din,
  input  wire logic pop,
  output logic full,
  output logic empty,
  output psola_pkg::psola_item_t dout
);

  psola_pkg::psola_item_t q [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- design/psola_back.sv -----
`default_nettype none
`include "psola_pitch_shift_frame_unit_macros.svh"
module psola_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire psola_pkg::psola_cfg_t cfg,
  input  wire logic q_empty,
  input  wire psola_pkg::psola_item_t q_item,
  output logic pop,
  output logic clearing,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [31:0] out_sample,
  output logic frame_ready
);

  localparam int AW = $clog2(psola_pkg::MaxFrame);

  psola_pkg::psola_state_t state, state_next;

  logic signed [15:0] in_mem [psola_pkg::MaxFrame];
  logic [31:0] acc_mem [psola_pkg::MaxFrame];
  logic [31:0] out_mem [psola_pkg::MaxFrame];
  logic signed [15:0] in_rd;
  logic [31:0] acc_rd, out_rd;

  logic [AW-1:0] ci;
  logic have_frame, last_r;
  logic [11:0] ai_p1;
  logic [20:0] si;
  logic [9:0] start_r, cnt_r, k;
  logic [9:0] kk_r;
  logic force_r;
  logic [26:0] w_r;
  logic signed [43:0] prod_r;

  // window and block geometry
  logic [8:0] a_eff;
  logic [7:0] half;
  logic [9:0] n, mid;
  logic [20:0] j;
  logic [10:0] start_c, end_c, endc_c;
  logic blk_ok, blk_skip, k_done, copy_done, clr_done;
  logic signed [43:0] rnd;
  logic signed [43:0] sh;
  logic [10:0] k1;

  assign a_eff = (cfg.ap == 9'd0) ? 9'd1 : cfg.ap;
  assign half = a_eff[8:1];
  assign n = 10'(a_eff) + 10'(half);
  assign mid = {1'b0, n[9:1]};
  assign j = si + 21'(k);
  assign blk_ok = (12'(ai_p1) + 12'(a_eff)) < 12'(cfg.len);
  assign blk_skip = si >= 21'(cfg.len);
  assign start_c = (ai_p1 > 12'(half)) ? 11'(ai_p1 - 12'(half)) : 11'd0;
  assign end_c = start_c + 11'(n);
  assign endc_c = (end_c > (11'(cfg.len) - 11'd1)) ? (11'(cfg.len) - 11'd1) : end_c;
  assign k1 = 11'(k) + 11'd1;
  assign k_done = (k1 > 11'(cnt_r)) || ((si + 21'(k1)) >= 21'(cfg.len));
  assign copy_done = (12'(ci) == (12'(cfg.len) - 12'd1));
  assign clr_done = (ci == AW'(psola_pkg::MaxFrame - 1));
  assign rnd = prod_r + 44'(psola_pkg::RoundBias);
  assign sh = rnd >>> psola_pkg::QBits;

  always_comb begin
    state_next = state;
    pop = 1'b0;
    clearing = (state == psola_pkg::ST_CLR);
    case (state)
      psola_pkg::ST_CLR: if (clr_done) state_next = psola_pkg::ST_IDLE;
      psola_pkg::ST_IDLE: begin
        if (!q_empty && !out_valid) begin
          pop = 1'b1;
          state_next = psola_pkg::ST_RESP;
        end
      end
      psola_pkg::ST_RESP: state_next = last_r ? psola_pkg::ST_CHK : psola_pkg::ST_IDLE;
      psola_pkg::ST_CHK: begin
        if (!blk_ok) state_next = psola_pkg::ST_CRD;
        else if (!blk_skip) state_next = psola_pkg::ST_RD;
      end
      psola_pkg::ST_RD: state_next = psola_pkg::ST_WT;
      psola_pkg::ST_WT: state_next = psola_pkg::ST_MUL;
      psola_pkg::ST_MUL: state_next = psola_pkg::ST_WR;
      psola_pkg::ST_WR: state_next = k_done ? psola_pkg::ST_CHK : psola_pkg::ST_RD;
      psola_pkg::ST_CRD: state_next = psola_pkg::ST_CWR;
      psola_pkg::ST_CWR: state_next = copy_done ? psola_pkg::ST_IDLE : psola_pkg::ST_CRD;
      default: state_next = psola_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= psola_pkg::ST_CLR;
    else state <= state_next;
  end

  // memories
  always_ff @(posedge clk) begin
    if (pop) in_mem[AW'(q_item.idx)] <= q_item.sample;
    if (state == psola_pkg::ST_RD) in_rd <= in_mem[AW'(11'(start_r) + 11'(k))];
  end

  always_ff @(posedge clk) begin
    if (state == psola_pkg::ST_CLR || state == psola_pkg::ST_CWR) acc_mem[ci] <= '0;
    else if (state == psola_pkg::ST_WR) acc_mem[AW'(j)] <= acc_rd + 32'(sh);
    if (state == psola_pkg::ST_RD) acc_rd <= acc_mem[AW'(j)];
    else if (state == psola_pkg::ST_CRD) acc_rd <= acc_mem[ci];
  end

  always_ff @(posedge clk) begin
    if (state == psola_pkg::ST_CLR) out_mem[ci] <= '0;
    else if (state == psola_pkg::ST_CWR) out_mem[ci] <= acc_rd;
    if (pop) out_rd <= out_mem[AW'(q_item.idx)];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) last_r <= q_item.last;
    if (state == psola_pkg::ST_RD) begin
      kk_r <= (k <= mid) ? k : n - k;
      force_r <= ~n[0] && (k == mid);
    end
    if (state == psola_pkg::ST_WT)
      w_r <= force_r ? 27'(psola_pkg::ForceWeight) : 27'(kk_r) * 27'(cfg.slope);
    if (state == psola_pkg::ST_MUL) prod_r <= 44'(in_rd) * $signed({17'd0, w_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ci <= '0;
      have_frame <= 1'b0;
      ai_p1 <= '0;
      si <= '0;
      k <= '0;
      start_r <= '0;
      cnt_r <= '0;
    end else begin
      case (state)
        psola_pkg::ST_CLR: ci <= clr_done ? '0 : ci + AW'(1);
        psola_pkg::ST_RESP: begin
          ai_p1 <= '0;
          si <= '0;
        end
        psola_pkg::ST_CHK: begin
          ci <= '0;
          k <= '0;
          start_r <= start_c[9:0];
          cnt_r <= 10'(endc_c - start_c);
          if (blk_ok && blk_skip) begin
            ai_p1 <= ai_p1 + 12'(a_eff);
            si <= si + 21'(cfg.sp);
          end
        end
        psola_pkg::ST_WR: begin
          if (k_done) begin
            ai_p1 <= ai_p1 + 12'(a_eff);
            si <= si + 21'(cfg.sp);
          end else begin
            k <= k1[9:0];
          end
        end
        psola_pkg::ST_CWR: begin
          ci <= ci + AW'(1);
          if (copy_done) have_frame <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == psola_pkg::ST_RESP) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == psola_pkg::ST_RESP) begin
      out_sample <= have_frame ? $signed(out_rd) : 32'sd0;
      frame_ready <= have_frame;
    end
  end

  `PSOLA_ASSERT_NOW(a_pop_idle, clk, rst, pop, state == psola_pkg::ST_IDLE && !q_empty)
  `PSOLA_ASSERT_NOW(a_resp_free, clk, rst, state == psola_pkg::ST_RESP, !out_valid)
  `PSOLA_ASSERT_NOW(a_acc_in_frame, clk, rst, state == psola_pkg::ST_WR, j < 21'(cfg.len))
  `PSOLA_ASSERT_NEXT(a_copy_sets_frame, clk, rst,
    state == psola_pkg::ST_CWR && copy_done, have_frame)

endmodule
`default_nettype wire

// ----- design/psola_pitch_shift_frame_unit.sv -----
// an accepted sample is queued, popped in IDLE and answered in RESP; out_valid is
// registered from RESP, and a new sample is popped only in IDLE with out_valid low
// the sample that completes a frame adds RD, WT, MUL and WR per weighted sample (one
// multiply and accumulator read-modify-write), CHK per block, CRD and CWR per copied sample
// reset: synchronous, clears control, then a clear pass over every frame address zeroes
// the accumulator and output frame while no input transaction is taken
`default_nettype none
module psola_pitch_shift_frame_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [15:0] in_sample,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [31:0] out_sample,
  output logic frame_ready,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [16:0] cfg_data
);

  logic [9:0] frame_length;
  logic [8:0] analysis_period;
  logic [9:0] synthesis_period;
  logic [16:0] window_slope;
  psola_pkg::psola_cfg_t cfg;
  psola_pkg::psola_item_t f_item, q_item;
  logic push, pop, q_full, q_empty, clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= 10'd512;
      analysis_period <= 9'd100;
      synthesis_period <= 10'd100;
      window_slope <= 17'd437;
    end else if (cfg_we) begin
      case (cfg_index)
        psola_pkg::RegFrameLength: frame_length <= cfg_data[9:0];
        psola_pkg::RegAnalysisPeriod: analysis_period <= cfg_data[8:0];
        psola_pkg::RegSynthesisPeriod: synthesis_period <= cfg_data[9:0];
        psola_pkg::RegWindowSlope: window_slope <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(frame_length) > psola_pkg::MaxFrame) cfg.len = 10'(psola_pkg::MaxFrame);
    else if (frame_length == 10'd0) cfg.len = 10'd1;
    else cfg.len = frame_length;
    cfg.ap = analysis_period;
    cfg.sp = synthesis_period;
    cfg.slope = window_slope;
  end

  psola_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_sample(in_sample), .len(cfg.len),
    .q_full(q_full), .hold(clearing), .in_stall(in_stall), .push(push), .item(f_item)
  );

  psola_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(f_item), .pop(pop),
    .full(q_full), .empty(q_empty), .dout(q_item)
  );

  psola_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(q_empty), .q_item(q_item), .pop(pop),
    .clearing(clearing), .out_valid(out_valid), .out_stall(out_stall),
    .out_sample(out_sample), .frame_ready(frame_ready)
  );

endmodule
`default_nettype wire
